@@ rtl/core/tces_pkg.sv @@
// Shared types and constants for the timed control-voltage event scheduler.
// No dependencies.
`default_nettype none

package tces_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int VAL_W       = 32;
    localparam int ENT_W       = TIME_W + VAL_W;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [TIME_W-1:0]       event_time;
        logic signed [VAL_W-1:0] event_value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] cv_value;
        logic                    is_frame;
        logic                    dropped;
    } res_t;

    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [VAL_W-1:0]  ev_value;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/timed_cv_event_scheduler.sv @@
// Top level of the timed control-voltage event scheduler: front queue, engine, output register.
// Depends on tces_pkg, tces_front and tces_back.
//
//   Channel   Ports                       Direction  Carries
//   request   s_valid / s_ready / s_data  in         req_t (push or frame tick)
//   result    m_valid / m_ready / m_data  out        res_t (ack or frame sample)
//
// In the engine a push walks down from the tail over the N entries with a later time, moving
// each up one slot (one RAM read and one write per step); a push to a full store is dropped.
// A tick dispatches every due event from the head through the same RAM's read port, and stops
// at the first entry that is not yet due or when the store is empty.
// Reset is synchronous and active low; the event store needs no clearing.
// A two-entry request queue and a result register let either side stall independently.
`default_nettype none

module timed_cv_event_scheduler import tces_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_data
);

    logic q_valid, q_ready;
    req_t q_data;
    logic r_valid, r_ready;
    res_t r_data;
    logic m_valid_reg;
    res_t m_data_reg;

    tces_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    tces_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .r_valid (r_valid),
        .r_ready (r_ready),
        .r_data  (r_data)
    );

    assign r_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (r_valid && r_ready) begin
            m_data_reg <= r_data;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (r_ready) begin
            m_valid_reg <= r_valid;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tces_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tces_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/core/tces_front.sv @@
// Front end: accepts request transfers into a two-entry queue for the engine.
// Depends on tces_pkg.
`default_nettype none

module tces_front import tces_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_data,
    output logic      q_valid,
    input  wire logic q_ready,
    output req_t      q_data
);

    req_t       slot_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_data;
        end
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tces_back.sv @@
// Back end: sorted circular event store in RAM, insert walk and per-frame dispatch.
// Depends on tces_pkg and tces_ram.
`default_nettype none

module tces_back import tces_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire req_t q_data,
    output logic      r_valid,
    input  wire logic r_ready,
    output res_t      r_data
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_INS_RD  = 6'b000010,
        ST_INS_CMP = 6'b000100,
        ST_DSP_RD  = 6'b001000,
        ST_DSP_CMP = 6'b010000,
        ST_RESP    = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [TIME_W-1:0] frame_reg, frame_next;
    logic [VAL_W-1:0]  held_reg, held_next;
    req_t              req_reg, req_next;
    res_t              res_reg, res_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    entry_t            wr_data, rd_data;

    // Offset from head into the circular store, wrapping at the depth.
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    tces_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign q_ready = (state_reg == ST_IDLE);
    assign r_valid = (state_reg == ST_RESP);
    assign r_data  = res_reg;

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        frame_next = frame_reg;
        held_next  = held_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = slot(head_reg, pos_reg);
        wr_data    = '{ev_time: req_reg.event_time, ev_value: req_reg.event_value};
        rd_addr    = head_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    req_next = q_data;
                    pos_next = count_reg;
                    if (q_data.req_type == REQ_TICK) begin
                        state_next = ST_DSP_RD;
                    end else if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                        res_next   = '{cv_value: '0, is_frame: 1'b0, dropped: 1'b1};
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    res_next   = '{cv_value: '0, is_frame: 1'b0, dropped: 1'b0};
                    state_next = ST_RESP;
                end else begin
                    rd_addr    = slot(head_reg, pos_reg - 1'b1);
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                // Later entries move up one slot; equal times stay ahead of the new one.
                wr_en = 1'b1;
                if (rd_data.ev_time > req_reg.event_time) begin
                    wr_data    = rd_data;
                    pos_next   = pos_reg - 1'b1;
                    state_next = ST_INS_RD;
                end else begin
                    count_next = count_reg + 1'b1;
                    res_next   = '{cv_value: '0, is_frame: 1'b0, dropped: 1'b0};
                    state_next = ST_RESP;
                end
            end
            ST_DSP_RD: begin
                if (count_reg == '0) begin
                    res_next   = '{cv_value: held_reg, is_frame: 1'b1, dropped: 1'b0};
                    frame_next = frame_reg + 1'b1;
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_DSP_CMP;
                end
            end
            ST_DSP_CMP: begin
                if (rd_data.ev_time <= frame_reg) begin
                    held_next  = rd_data.ev_value;
                    head_next  = slot(head_reg, CNT_W'(1));
                    count_next = count_reg - 1'b1;
                    state_next = ST_DSP_RD;
                end else begin
                    res_next   = '{cv_value: held_reg, is_frame: 1'b1, dropped: 1'b0};
                    frame_next = frame_reg + 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (r_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        req_reg <= req_next;
        res_reg <= res_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            frame_reg <= '0;
            held_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            frame_reg <= frame_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

@@ test/timed_cv_event_scheduler_tb.sv @@
// Testbench for the timed control-voltage event scheduler: random and directed pushes and
// frame ticks, each result checked against an in-bench model of the sorted event queue.
// Depends on tces_pkg and timed_cv_event_scheduler.
`timescale 1ns / 100ps

module timed_cv_event_scheduler_tb;
    import tces_pkg::*;

    class cv_scoreboard;
        logic [TIME_W-1:0] frame_cnt;
        logic [VAL_W-1:0]  held;
        entry_t            events[$];
        res_t              pending[$];
        int                mismatches;

        function new();
            frame_cnt  = '0;
            held       = '0;
            mismatches = 0;
        endfunction

        // Works out the result of one accepted request and updates the queue model.
        function void note_request(req_t rq);
            res_t   r;
            entry_t e;
            int     pos;
            r = '0;
            if (rq.req_type == REQ_PUSH) begin
                if (events.size() >= QUEUE_DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < events.size() && events[pos].ev_time <= rq.event_time)
                        pos++;
                    e.ev_time  = rq.event_time;
                    e.ev_value = rq.event_value;
                    events.insert(pos, e);
                end
            end else begin
                while (events.size() > 0 && events[0].ev_time <= frame_cnt) begin
                    held = events[0].ev_value;
                    void'(events.pop_front());
                end
                r.cv_value = held;
                r.is_frame = 1'b1;
                frame_cnt  = frame_cnt + 1;
            end
            pending.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.cv_value !== exp_r.cv_value || got.is_frame !== exp_r.is_frame ||
                got.dropped !== exp_r.dropped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected cv=%h frame=%b drop=%b, %s",
                             exp_r.cv_value, exp_r.is_frame, exp_r.dropped,
                             $sformatf("got cv=%h frame=%b drop=%b",
                                       got.cv_value, got.is_frame, got.dropped));
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    res_t m_data;

    cv_scoreboard sb;
    bit           hold_off;
    bit           sending_done;
    int           frames_sent;

    timed_cv_event_scheduler u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Offers one request, holds it until the transfer, then idles for a random gap.
    task automatic send_request(input req_t rq, input int max_gap);
        int gap;
        s_data  <= rq;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(rq);
        gap = $urandom_range(0, max_gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic push_event(input logic [31:0] t, input logic [31:0] v, input int max_gap);
        req_t rq;
        rq.req_type    = REQ_PUSH;
        rq.event_time  = t;
        rq.event_value = v;
        send_request(rq, max_gap);
    endtask

    task automatic frame_tick(input int max_gap);
        req_t rq;
        rq             = '0;
        rq.req_type    = REQ_TICK;
        rq.event_time  = $urandom;
        rq.event_value = $urandom;
        frames_sent++;
        send_request(rq, max_gap);
    endtask

    // Random event time: mostly near the current frame, sometimes immediate or far off.
    function automatic logic [31:0] pick_time();
        logic [31:0] now;
        now = sb.frame_cnt;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2:       return now - $urandom_range(1, 8);
            default: return now + $urandom_range(0, 12);
        endcase
    endfunction

    // Result side: random stalls, with one long hold-off requested by the sender.
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (frames_sent > 600 && frames_sent < 700)
                stall = 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_data);
        end
    end

    initial begin
        int gap_max;
        int wait_cnt;
        sb           = new();
        s_valid      = 1'b0;
        s_data       = '0;
        aresetn      = 1'b0;
        hold_off     = 1'b0;
        sending_done = 1'b0;
        frames_sent  = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extreme fields, immediate, late and equal-time events, a multi-event tick.
        push_event(32'h0, 32'h8000_0000, 2);
        push_event(32'hFFFF_FFFF, 32'h7FFF_FFFF, 2);
        push_event(32'h0, 32'hFFFF_FFFF, 2);
        frame_tick(2);
        push_event(32'd3, 32'h0001_0000, 0);
        push_event(32'd3, 32'h0002_0000, 0);
        push_event(32'd2, 32'hFFFE_0000, 0);
        frame_tick(0);
        frame_tick(0);
        frame_tick(0);
        frame_tick(0);
        push_event(32'd1, 32'h1234_5678, 0);
        frame_tick(1);
        // Fill the queue past its depth to provoke drops; these drain over later frames.
        for (int i = 0; i < QUEUE_DEPTH + 3; i++)
            push_event(sb.frame_cnt + $urandom_range(0, 40), $urandom, 0);
        for (int i = 0; i < 3; i++) frame_tick(0);
        hold_off = 1'b1;

        // Random mix of pushes and ticks.
        for (int i = 0; i < 1300; i++) begin
            gap_max = ($urandom_range(0, 4) == 0) ? 0 : 16;
            if ($urandom_range(0, 1))
                push_event(pick_time(), $urandom, gap_max);
            else
                frame_tick(gap_max);
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;

        wait_cnt = 0;
        while (sb.pending.size() > 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (300) @(posedge aclk);
        if (sb.pending.size() == 0 && sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
